FILE: hw/rtl/dbpw_pkg.sv
package dbpw_pkg;

   localparam int MAX_WIDTH_DEFAULT = 512;
   localparam int MAX_HEIGHT_DEFAULT = 512;
   localparam int DEPTH_FRACTION_BITS_DEFAULT = 14;

   localparam int COORD_W = 10;
   localparam int CSR_DATA_W = 10;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 1'd1;

   localparam logic [CSR_DATA_W-1:0] SCREEN_WIDTH_RESET = 10'd512;
   localparam logic [CSR_DATA_W-1:0] SCREEN_HEIGHT_RESET = 10'd512;

   localparam logic [31:0] BLACK_RGBA = 32'h0000_00FF;
   localparam logic signed [15:0] DEPTH_MAX = 16'sh7FFF;

   typedef enum logic [1:0] {
      KIND_FRAGMENT = 2'd0,
      KIND_CLEAR    = 2'd1,
      KIND_READ     = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_WRITTEN     = 3'd0,
      STATUS_HIDDEN      = 3'd1,
      STATUS_DEPTH_RANGE = 3'd2,
      STATUS_OUT_OF_BOUNDS = 3'd3,
      STATUS_CLEARED     = 3'd4,
      STATUS_READ_DONE   = 3'd5
   } status_type;

   typedef struct packed {
      kind_type kind;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic signed [15:0] depth;
      logic [31:0] colour;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [31:0] read_colour;
   } rsp_type;

endpackage

FILE: hw/rtl/depth_buffer_pixel_write.sv
// Depth-tested frame store with a colour store and a depth store in two memories.
// Items enter on the req_ channel (valid/stall) and results leave on the rsp_ channel.
// A fragment item is bounds checked, range checked, flipped in y and written only when
// its depth is below the stored depth. A read item returns the stored colour at the raw
// position. A clear item sweeps the area in use to black at depth 2.0 (saturated).
// Every item except an unused kind gives exactly one result.
// A fragment or read goes through a memory read and then a compare and write back,
// and the block takes no new item until it has finished the one before.
// The result is held in an output register; while the receiver stalls it, the block
// can still take one more item, then keeps req_stall high until the register frees up
// and that item's result can move into it.
// A clear sweeps width times height positions with req_stall high. After reset the
// block runs an initialization sweep of MAX_WIDTH times MAX_HEIGHT positions with
// req_stall high; configuration writes are taken during it. The user writes the screen
// size registers through the csr_ port only while idle; the block does not enforce it.
module depth_buffer_pixel_write
   import dbpw_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT,
   parameter int DEPTH_FRACTION_BITS = DEPTH_FRACTION_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_type rsp_payload,
   input  logic csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int XAW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YAW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int AW = XAW + YAW;
   localparam int XCW = ($clog2(MAX_WIDTH + 1) > COORD_W) ? $clog2(MAX_WIDTH + 1) : COORD_W;
   localparam int YCW = ($clog2(MAX_HEIGHT + 1) > COORD_W) ? $clog2(MAX_HEIGHT + 1) : COORD_W;
   localparam longint DEPTH_ONE = longint'(1) << DEPTH_FRACTION_BITS;
   localparam longint CLEAR_WIDE = longint'(2) << DEPTH_FRACTION_BITS;
   localparam logic signed [15:0] CLEAR_DEPTH =
      (CLEAR_WIDE > longint'(DEPTH_MAX)) ? DEPTH_MAX : 16'(CLEAR_WIDE);

   typedef enum logic [1:0] {
      S_INIT,
      S_IDLE,
      S_LOOK,
      S_CLEAR
   } state_type;

   typedef enum logic [1:0] {
      OP_FRAGMENT,
      OP_READ,
      OP_FIXED
   } op_type;

   logic [15:0] depth_mem [2**AW];
   logic [31:0] colour_mem [2**AW];

   state_type state_ff, state_in;
   op_type op_ff, op_in;
   status_type status_ff, status_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic signed [15:0] depth_ff, depth_in;
   logic [31:0] colour_ff, colour_in;
   logic [XCW-1:0] col_ff, col_in, wlim_ff, wlim_in;
   logic [YCW-1:0] row_ff, row_in, hlim_ff, hlim_in;
   logic [CSR_DATA_W-1:0] width_ff, width_in, height_ff, height_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic signed [15:0] rd_depth_ff;
   logic [31:0] rd_colour_ff;

   logic mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic mem_we;
   logic [AW-1:0] mem_wr_addr;
   logic [15:0] mem_wr_depth;
   logic [31:0] mem_wr_colour;

   logic [XCW-1:0] w_eff, x_ext;
   logic [YCW-1:0] h_eff, y_ext, y_flip;
   logic out_of_bounds, depth_bad, slot_free, sweep_done;
   longint z_ext;

   always_comb begin
      x_ext = XCW'(req_payload.pos_x);
      y_ext = YCW'(req_payload.pos_y);
      w_eff = (XCW'(width_ff) < XCW'(MAX_WIDTH)) ? XCW'(width_ff) : XCW'(MAX_WIDTH);
      h_eff = (YCW'(height_ff) < YCW'(MAX_HEIGHT)) ? YCW'(height_ff) : YCW'(MAX_HEIGHT);
      y_flip = h_eff - YCW'(1) - y_ext;
      out_of_bounds = (x_ext >= w_eff) || (y_ext >= h_eff);
      z_ext = longint'(req_payload.depth);
      depth_bad = (z_ext < -DEPTH_ONE) || (z_ext > DEPTH_ONE);
      slot_free = !rsp_valid_ff || !rsp_stall;
      sweep_done = (row_ff == hlim_ff) && (col_ff == wlim_ff);
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      status_in = status_ff;
      addr_in = addr_ff;
      depth_in = depth_ff;
      colour_in = colour_ff;
      col_in = col_ff;
      row_in = row_ff;
      wlim_in = wlim_ff;
      hlim_in = hlim_ff;
      width_in = width_ff;
      height_in = height_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      mem_rd_en = 1'b0;
      mem_rd_addr = {x_ext[XAW-1:0], y_ext[YAW-1:0]};
      mem_we = 1'b0;
      mem_wr_addr = {col_ff[XAW-1:0], row_ff[YAW-1:0]};
      mem_wr_depth = CLEAR_DEPTH;
      mem_wr_colour = BLACK_RGBA;

      if (csr_we) begin
         case (csr_index)
            CSR_SCREEN_WIDTH: width_in = csr_wdata;
            CSR_SCREEN_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end

      if (row_ff == hlim_ff) begin
         row_in = '0;
         col_in = col_ff + XCW'(1);
      end else begin
         row_in = row_ff + YCW'(1);
      end

      case (state_ff)
         S_INIT: begin
            mem_we = 1'b1;
            mem_wr_depth = DEPTH_MAX;
            if (sweep_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            col_in = col_ff;
            row_in = row_ff;
            depth_in = req_payload.depth;
            colour_in = req_payload.colour;
            if (req_valid) begin
               state_in = S_LOOK;
               op_in = OP_FIXED;
               case (req_payload.kind)
                  KIND_FRAGMENT: begin
                     if (out_of_bounds) begin
                        status_in = STATUS_OUT_OF_BOUNDS;
                     end else if (depth_bad) begin
                        status_in = STATUS_DEPTH_RANGE;
                     end else begin
                        op_in = OP_FRAGMENT;
                        mem_rd_en = 1'b1;
                        mem_rd_addr = {x_ext[XAW-1:0], y_flip[YAW-1:0]};
                        addr_in = mem_rd_addr;
                     end
                  end
                  KIND_READ: begin
                     if (out_of_bounds) begin
                        status_in = STATUS_OUT_OF_BOUNDS;
                     end else begin
                        op_in = OP_READ;
                        mem_rd_en = 1'b1;
                     end
                  end
                  KIND_CLEAR: begin
                     status_in = STATUS_CLEARED;
                     if (w_eff != '0 && h_eff != '0) begin
                        state_in = S_CLEAR;
                        col_in = '0;
                        row_in = '0;
                        wlim_in = w_eff - XCW'(1);
                        hlim_in = h_eff - YCW'(1);
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_CLEAR: begin
            mem_we = 1'b1;
            if (sweep_done) begin
               state_in = S_LOOK;
               op_in = OP_FIXED;
            end
         end
         S_LOOK: begin
            col_in = col_ff;
            row_in = row_ff;
            mem_wr_addr = addr_ff;
            mem_wr_depth = depth_ff;
            mem_wr_colour = colour_ff;
            if (slot_free) begin
               state_in = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in.read_colour = '0;
               rsp_in.status = status_ff;
               case (op_ff)
                  OP_FRAGMENT: begin
                     if (depth_ff < rd_depth_ff) begin
                        mem_we = 1'b1;
                        rsp_in.status = STATUS_WRITTEN;
                     end else begin
                        rsp_in.status = STATUS_HIDDEN;
                     end
                  end
                  OP_READ: begin
                     rsp_in.status = STATUS_READ_DONE;
                     rsp_in.read_colour = rd_colour_ff;
                  end
                  default: ;
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         col_ff <= '0;
         row_ff <= '0;
         wlim_ff <= XCW'(MAX_WIDTH - 1);
         hlim_ff <= YCW'(MAX_HEIGHT - 1);
         width_ff <= SCREEN_WIDTH_RESET;
         height_ff <= SCREEN_HEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
         op_ff <= OP_FIXED;
      end else begin
         state_ff <= state_in;
         col_ff <= col_in;
         row_ff <= row_in;
         wlim_ff <= wlim_in;
         hlim_ff <= hlim_in;
         width_ff <= width_in;
         height_ff <= height_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff <= op_in;
      end
      status_ff <= status_in;
      addr_ff <= addr_in;
      depth_ff <= depth_in;
      colour_ff <= colour_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         depth_mem[mem_wr_addr] <= mem_wr_depth;
         colour_mem[mem_wr_addr] <= mem_wr_colour;
      end
      if (mem_rd_en) begin
         rd_depth_ff <= depth_mem[mem_rd_addr];
         rd_colour_ff <= colour_mem[mem_rd_addr];
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
